/* rtl/fms_pkg.sv */
// flight mode sequencer package: mode and command codes, limits and shared types
// no dependencies; used by every module of the sequencer

package fms_pkg;

    typedef enum logic [2:0] {
        MODE_DISARMED = 3'd0,
        MODE_ARMED    = 3'd1,
        MODE_FLYING   = 3'd2,
        MODE_LAND     = 3'd3,
        MODE_FLIP     = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        CMD_NONE       = 3'd0,
        CMD_DISARM     = 3'd1,
        CMD_ARM        = 3'd2,
        CMD_ZERO       = 3'd3,
        CMD_FLY        = 3'd4,
        CMD_LAND       = 3'd5,
        CMD_FLIP       = 3'd6,
        CMD_RATE_RESET = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        CFG_GYRO_OFS     = 3'd0,
        CFG_ACCEL_OFS    = 3'd1,
        CFG_LINK_TIMEOUT = 3'd2,
        CFG_ARM_THR_MAX  = 3'd3,
        CFG_TAKEOFF_MIN  = 3'd4,
        CFG_FLIP_THR_MIN = 3'd5
    } cfg_idx_t;

    localparam int ACC_W = 50;

    localparam logic [31:0]      LAND_RAMP_MS     = 32'd2500;
    localparam logic [31:0]      LAND_HALF_MS     = 32'd1250;
    localparam logic [16:0]      LAND_STILL_MAX   = 17'd409;
    // floor(x / 25) for x below 43690 as (x * 5243) >> 17
    localparam logic [12:0]      LAND_RECIP       = 13'd5243;
    localparam logic [31:0]      FLIP_MAX_MS      = 32'd800;
    localparam logic [9:0]       FLIP_THROTTLE    = 10'd800;
    localparam logic [ACC_W-1:0] FLIP_TURN_UNITS  = 50'd5760000000;
    localparam logic [ACC_W-1:0] ACC_MAX          = {ACC_W{1'b1}};
    localparam logic [31:0]      FIRST_DT_US      = 32'd1000;
    localparam logic [9:0]       THR_MAX          = 10'd1000;

    localparam logic [15:0] RST_LINK_TIMEOUT = 16'd500;
    localparam logic [9:0]  RST_ARM_THR_MAX  = 10'd50;
    localparam logic [9:0]  RST_TAKEOFF_MIN  = 10'd100;
    localparam logic [9:0]  RST_FLIP_THR_MIN = 10'd300;

    typedef struct packed {
        logic signed [15:0] gyro_x_offset;
        logic signed [15:0] accel_z_offset;
        logic [15:0]        link_timeout_ms;
        logic [9:0]         arm_throttle_max;
        logic [9:0]         takeoff_throttle_min;
        logic [9:0]         flip_throttle_min;
    } cfg_t;

    typedef struct packed {
        logic               pkt_valid;
        logic               arm_switch;
        logic               flip_request;
        logic               land_request;
        logic [9:0]         throttle;
        logic [31:0]        now_ms;
        logic [31:0]        now_us;
        logic signed [15:0] gyro_x_raw;
        logic signed [15:0] accel_z_raw;
    } tick_t;

    typedef struct packed {
        mode_t             mode;
        logic [31:0]       last_packet_ms;
        logic [31:0]       last_tick_us;
        logic [31:0]       land_t0_ms;
        logic [31:0]       flip_t0_ms;
        logic [ACC_W-1:0]  flip_angle_acc;
        logic              tick_seen;
    } state_t;

    typedef struct packed {
        mode_t      mode;
        cmd_t       motor_command;
        logic [9:0] throttle_out;
    } result_t;

endpackage

/* rtl/fms_tick_if.sv */
// tick channel of the flight mode sequencer: valid/ready plus one control tick word
// no dependencies

interface fms_tick_if;
    logic               valid;
    logic               ready;
    logic               pkt_valid;
    logic               arm_switch;
    logic               flip_request;
    logic               land_request;
    logic [9:0]         throttle;
    logic [31:0]        now_ms;
    logic [31:0]        now_us;
    logic signed [15:0] gyro_x_raw;
    logic signed [15:0] accel_z_raw;

    modport source (
        output valid, pkt_valid, arm_switch, flip_request, land_request,
        output throttle, now_ms, now_us, gyro_x_raw, accel_z_raw,
        input  ready
    );
    modport sink (
        input  valid, pkt_valid, arm_switch, flip_request, land_request,
        input  throttle, now_ms, now_us, gyro_x_raw, accel_z_raw,
        output ready
    );
endinterface

/* rtl/fms_result_if.sv */
// result channel of the flight mode sequencer: valid/ready plus one motor command word
// no dependencies

interface fms_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [2:0] motor_command;
    logic [9:0] throttle_out;

    modport source (
        output valid, mode, motor_command, throttle_out,
        input  ready
    );
    modport sink (
        input  valid, mode, motor_command, throttle_out,
        output ready
    );
endinterface

/* rtl/fms_cfg_if.sv */
// configuration write channel of the flight mode sequencer: valid/ready, index, data
// no dependencies

interface fms_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

/* rtl/fms_cfg_regs.sv */
// configuration register file of the flight mode sequencer
// depends on fms_pkg and fms_cfg_if

module fms_cfg_regs (
    input  logic         clk,
    input  logic         rst_n,
    fms_cfg_if.sink      cfg,
    output fms_pkg::cfg_t regs
);
    import fms_pkg::*;

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.gyro_x_offset        <= '0;
            regs_reg.accel_z_offset       <= '0;
            regs_reg.link_timeout_ms      <= RST_LINK_TIMEOUT;
            regs_reg.arm_throttle_max     <= RST_ARM_THR_MAX;
            regs_reg.takeoff_throttle_min <= RST_TAKEOFF_MIN;
            regs_reg.flip_throttle_min    <= RST_FLIP_THR_MIN;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_GYRO_OFS:     regs_reg.gyro_x_offset        <= cfg.data;
                CFG_ACCEL_OFS:    regs_reg.accel_z_offset       <= cfg.data;
                CFG_LINK_TIMEOUT: regs_reg.link_timeout_ms      <= cfg.data;
                CFG_ARM_THR_MAX:  regs_reg.arm_throttle_max     <= cfg.data[9:0];
                CFG_TAKEOFF_MIN:  regs_reg.takeoff_throttle_min <= cfg.data[9:0];
                CFG_FLIP_THR_MIN: regs_reg.flip_throttle_min    <= cfg.data[9:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

/* rtl/fms_step.sv */
// one control tick of the flight mode sequencer: next state and result word
// depends on fms_pkg

module fms_step (
    input  fms_pkg::tick_t   tick,
    input  fms_pkg::state_t  cur,
    input  fms_pkg::cfg_t    regs,
    output fms_pkg::state_t  nxt,
    output fms_pkg::result_t res
);
    import fms_pkg::*;

    logic [31:0]      dt;
    logic [31:0]      pkt_ms;
    logic [31:0]      since_pkt;
    logic             failsafe;
    logic [16:0]      gyro_diff;
    logic [15:0]      gyro_abs;
    logic [16:0]      accel_diff;
    logic [16:0]      accel_abs;
    logic [47:0]      inc;
    logic [ACC_W-1:0] room;
    logic [ACC_W-1:0] acc_sum;
    logic [31:0]      land_el;
    logic [31:0]      flip_el;
    logic             still;
    logic [11:0]      ramp;
    logic [26:0]      land_prod;
    logic [9:0]       land_thr;
    logic [9:0]       fly_thr;

    // shared datapath
    always_comb
    begin
        dt        = cur.tick_seen ? (tick.now_us - cur.last_tick_us) : FIRST_DT_US;
        pkt_ms    = tick.pkt_valid ? tick.now_ms : cur.last_packet_ms;
        since_pkt = tick.now_ms - pkt_ms;
        failsafe  = (since_pkt > {16'd0, regs.link_timeout_ms}) && (cur.mode != MODE_DISARMED);

        gyro_diff  = {tick.gyro_x_raw[15], tick.gyro_x_raw}
                   - {regs.gyro_x_offset[15], regs.gyro_x_offset};
        gyro_abs   = gyro_diff[16] ? 16'(-gyro_diff) : gyro_diff[15:0];
        accel_diff = {tick.accel_z_raw[15], tick.accel_z_raw}
                   - {regs.accel_z_offset[15], regs.accel_z_offset};
        accel_abs  = accel_diff[16] ? (17'd0 - accel_diff) : accel_diff;
        still      = accel_abs <= LAND_STILL_MAX;

        // saturating flip angle integration
        inc     = {16'd0, gyro_abs} * {16'd0, dt};
        room    = ACC_MAX - cur.flip_angle_acc;
        acc_sum = ({2'd0, inc} > room) ? ACC_MAX : (cur.flip_angle_acc + {2'd0, inc});

        land_el = tick.now_ms - cur.land_t0_ms;
        flip_el = tick.now_ms - cur.flip_t0_ms;

        // (2500 - el) * 400 / 2500 = floor(4 * (2500 - el) / 25)
        ramp      = LAND_RAMP_MS[11:0] - land_el[11:0];
        land_prod = {13'd0, ramp, 2'b00} * {14'd0, LAND_RECIP};
        land_thr  = {1'b0, land_prod[25:17]};

        fly_thr = (tick.throttle > THR_MAX) ? THR_MAX : tick.throttle;
    end

    // mode transitions
    always_comb
    begin
        nxt                = cur;
        nxt.tick_seen      = 1'b1;
        nxt.last_tick_us   = tick.now_us;
        nxt.last_packet_ms = pkt_ms;
        res.motor_command  = CMD_NONE;
        res.throttle_out   = '0;

        if (failsafe)
        begin
            nxt.mode          = MODE_DISARMED;
            res.motor_command = CMD_DISARM;
        end
        else if (tick.pkt_valid)
        begin
            unique case (cur.mode)
                MODE_DISARMED:
                begin
                    if (tick.arm_switch && (tick.throttle < regs.arm_throttle_max))
                    begin
                        nxt.mode          = MODE_ARMED;
                        res.motor_command = CMD_ARM;
                    end
                end
                MODE_ARMED:
                begin
                    if (!tick.arm_switch)
                    begin
                        nxt.mode          = MODE_DISARMED;
                        res.motor_command = CMD_DISARM;
                    end
                    else
                    begin
                        if (tick.throttle > regs.takeoff_throttle_min)
                        begin
                            nxt.mode = MODE_FLYING;
                        end
                        res.motor_command = CMD_ZERO;
                    end
                end
                MODE_FLYING:
                begin
                    if (!tick.arm_switch)
                    begin
                        nxt.mode          = MODE_DISARMED;
                        res.motor_command = CMD_DISARM;
                    end
                    else if (tick.land_request)
                    begin
                        nxt.land_t0_ms = tick.now_ms;
                        nxt.mode       = MODE_LAND;
                    end
                    else if (tick.flip_request && (tick.throttle > regs.flip_throttle_min))
                    begin
                        nxt.flip_angle_acc = '0;
                        nxt.flip_t0_ms     = tick.now_ms;
                        nxt.mode           = MODE_FLIP;
                    end
                    else
                    begin
                        res.motor_command = CMD_FLY;
                        res.throttle_out  = fly_thr;
                    end
                end
                MODE_LAND:
                begin
                    if ((land_el >= LAND_RAMP_MS) || (still && (land_el > LAND_HALF_MS)))
                    begin
                        nxt.mode          = MODE_DISARMED;
                        res.motor_command = CMD_DISARM;
                    end
                    else
                    begin
                        res.motor_command = CMD_LAND;
                        res.throttle_out  = land_thr;
                    end
                end
                MODE_FLIP:
                begin
                    nxt.flip_angle_acc = acc_sum;
                    if ((acc_sum >= FLIP_TURN_UNITS) || (flip_el > FLIP_MAX_MS))
                    begin
                        nxt.mode          = MODE_FLYING;
                        res.motor_command = CMD_RATE_RESET;
                    end
                    else
                    begin
                        res.motor_command = CMD_FLIP;
                        res.throttle_out  = FLIP_THROTTLE;
                    end
                end
                default:
                begin
                    nxt.mode = MODE_DISARMED;
                end
            endcase
        end

        res.mode = nxt.mode;
    end

endmodule

/* rtl/flight_mode_sequencer_top.sv */
// flight mode sequencer: top level with tick input register, mode state and result register
// depends on fms_pkg, fms_tick_if, fms_result_if, fms_cfg_if, fms_cfg_regs and fms_step
//
// tick: one word per control tick (packet flags, throttle, ms/us timestamps,
//   raw roll gyro and vertical accel), valid/ready, taken when both are high
// result: one word per tick (mode after the tick, motor command, throttle),
//   valid/ready, held stable until taken
// cfg: register writes (index 0..5: gyro offset, accel offset, link timeout, arm max,
//   takeoff min, flip min), always ready; user must write only while idle (not enforced)
// path: a tick is registered at the edge it is taken and the step logic runs
//   from that register, so its result word loads into the result register when
//   the registered tick advances
// throughput: one tick per cycle sustained while result.ready stays high, state and result load together
// reset: rst_n low clears both pipeline valids, puts the mode at disarmed, zeroes
//   the timestamps and flip accumulator, and loads the register defaults
// stall: while the result is not taken, the tick register holds one more word and
//   tick.ready drops only when both are full; nothing is lost or repeated

module flight_mode_sequencer_top (
    input  logic        clk,
    input  logic        rst_n,
    fms_tick_if.sink    tick,
    fms_result_if.source result,
    fms_cfg_if.sink     cfg
);
    import fms_pkg::*;

    cfg_t    regs;
    tick_t   tick_word;
    tick_t   tick_reg;
    logic    tick_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;
    result_t res_reg;
    logic    res_valid_reg;
    logic    advance;

    // configuration registers
    fms_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // pack the incoming word
    always_comb
    begin
        tick_word.pkt_valid    = tick.pkt_valid;
        tick_word.arm_switch   = tick.arm_switch;
        tick_word.flip_request = tick.flip_request;
        tick_word.land_request = tick.land_request;
        tick_word.throttle     = tick.throttle;
        tick_word.now_ms       = tick.now_ms;
        tick_word.now_us       = tick.now_us;
        tick_word.gyro_x_raw   = tick.gyro_x_raw;
        tick_word.accel_z_raw  = tick.accel_z_raw;
    end

    // the registered tick moves on when the result register is free or being drained
    assign advance    = tick_valid_reg && (!res_valid_reg || result.ready);
    assign tick.ready = !tick_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            tick_valid_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            tick_reg <= tick_word;
        end
    end

    // per-tick mode and command logic
    fms_step u_step (
        .tick (tick_reg),
        .cur  (state_reg),
        .regs (regs),
        .nxt  (state_next),
        .res  (res_next)
    );

    // sequencer state, committed together with the result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode           <= MODE_DISARMED;
            state_reg.last_packet_ms <= '0;
            state_reg.last_tick_us   <= '0;
            state_reg.land_t0_ms     <= '0;
            state_reg.flip_t0_ms     <= '0;
            state_reg.flip_angle_acc <= '0;
            state_reg.tick_seen      <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.mode          = res_reg.mode;
    assign result.motor_command = res_reg.motor_command;
    assign result.throttle_out  = res_reg.throttle_out;

endmodule
